// ----- rtl/core/pclip_pkg.sv -----
// ----------------------------------------------------------------------------
// pclip_pkg: shared types and constants for the single-plane polygon clipper
// Holds the payload structs, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package pclip_pkg;

	localparam int MaxVertices = 64;
	localparam int CountCapInt = (2 * MaxVertices > 255) ? 255 : 2 * MaxVertices;
	localparam logic [7:0] CountCap = 8'(CountCapInt);
	localparam int DistW = 50;

	localparam logic [1:0] RegNormalX = 2'd0;
	localparam logic [1:0] RegNormalY = 2'd1;
	localparam logic [1:0] RegNormalZ = 2'd2;
	localparam logic [1:0] RegOffset  = 2'd3;

	typedef struct packed {
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic               closes_polygon;
	} vert_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               vertex_valid;
		logic               polygon_done;
		logic [7:0]         vertex_count;
		logic               run_end;
	} vert_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIST0, ST_DIST1, ST_DIST2, ST_DIST3, ST_EDGE, ST_DIV,
		ST_LERP, ST_EMIT, ST_CHECK
	} ctrl_state_t;

	// source of an emitted item
	typedef enum logic [1:0] {
		SRC_B, SRC_P, SRC_DONE
	} emit_src_t;

	typedef struct packed {
		logic      load_in;     // capture input vertex
		logic      dist_step;   // one multiply-accumulate of the distance
		logic      dist_clr;
		logic      set_edge;    // select current edge
		logic      edge_close;  // 0: prev->cur, 1: cur->first
		logic      div_start;
		logic      div_step;
		logic      lerp_step;
		logic      emit;
		emit_src_t emit_src;
		logic      emit_last;
		logic      commit;      // update first/prev state
	} dp_cmd_t;

	typedef struct packed {
		logic       a_in;
		logic       b_in;
		logic       div_done;
		logic       lerp_done;
		logic       first_vtx;
		logic       closes;
	} dp_stat_t;

endpackage

// ----- rtl/core/polygon_clip_against_plane.sv -----
// ----------------------------------------------------------------------------
// polygon_clip_against_plane: one Sutherland-Hodgman plane stage
// Clips a streamed polygon against a configured plane in fixed point.
// ----------------------------------------------------------------------------
// One vertex is processed at a time, and a new vertex is not taken until the
// last one is finished. Each vertex runs a four-term distance and, unless it
// only opens a polygon, an edge check; each edge that crosses the plane adds a
// restoring divide and a per-coordinate interpolation before its results are
// emitted. A closing vertex also loads and checks its closing edge. Output
// items sit in a register and are held while stall is high.
module polygon_clip_against_plane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pclip_pkg::vert_in_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pclip_pkg::vert_out_t out_data
);
	import pclip_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy, in_fire, out_free;

	assign in_stall = busy;
	assign in_fire  = in_valid && !busy;
	assign out_free = !out_valid || !out_stall;

	pclip_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.stat(stat), .busy(busy), .cmd(cmd)
	);

	pclip_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_data(in_data), .cmd(cmd), .stat(stat),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// done items carry no vertex
	a_done_novert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.polygon_done |-> !out_data.vertex_valid)
		else $error("done item marked as vertex");

	// a done item always ends its run
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.polygon_done |-> out_data.run_end)
		else $error("done item without run_end");

	// no new emit while a stalled result is pending
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !cmd.emit)
		else $error("result overwritten");

endmodule

// ----- rtl/core/pclip_ctrl.sv -----
// ----------------------------------------------------------------------------
// pclip_ctrl: clipper sequencer
// Walks each vertex through distance, its edge, any closing edge and their emits.
// ----------------------------------------------------------------------------
module pclip_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_free,
	input  pclip_pkg::dp_stat_t stat,
	output logic               busy,
	output pclip_pkg::dp_cmd_t cmd
);
	import pclip_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        close_q, close_d;   // working on closing edge
	logic [1:0]  phase_q, phase_d;   // emit sequence position
	logic [1:0]  phase_d_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			close_q <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			state_q <= state_d;
			close_q <= close_d;
			phase_q <= phase_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// emit plan for the current edge: phase 0 intersection point, phase 1 b, phase 2 done
	always_comb begin
		state_d  = state_q;
		close_d  = close_q;
		phase_d  = phase_q;
		phase_d_w = 2'd0;
		cmd      = '0;
		cmd.edge_close = close_q;
		cmd.emit_src = SRC_B;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load_in = 1'b1;
					cmd.dist_clr = 1'b1;
					state_d = ST_DIST0;
				end
			end
			ST_DIST0, ST_DIST1, ST_DIST2: begin
				cmd.dist_step = 1'b1;
				state_d = ctrl_state_t'(state_q + 4'd1);
			end
			ST_DIST3: begin
				cmd.dist_step = 1'b1;
				if (stat.first_vtx && !stat.closes) begin
					// opening vertex has no edge yet: just record it
					close_d = 1'b1;
					phase_d = 2'd3;
					state_d = ST_EMIT;
				end else begin
					close_d = stat.first_vtx;
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				cmd.set_edge = 1'b1;
				state_d = ST_CHECK;
			end
			// classify the edge once its operands are loaded
			ST_CHECK: begin
				phase_d = 2'd0;
				if (!stat.a_in && !stat.b_in) begin
					state_d = ST_EMIT;
					phase_d = 2'd3;  // nothing from this edge
				end else if (stat.a_in && stat.b_in) begin
					state_d = ST_EMIT;
					phase_d = 2'd1;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_LERP;
				else cmd.div_step = 1'b1;
			end
			ST_LERP: begin
				cmd.lerp_step = 1'b1;
				if (stat.lerp_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// phase codes as in the emit plan above, with the top code for edge finished
				if (phase_q == 2'd3) begin
					if (!close_q && stat.closes) begin
						close_d = 1'b1;
						state_d = ST_EDGE;
					end else if (close_q && stat.closes) begin
						phase_d = 2'd2;
					end else begin
						cmd.commit = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.emit_src = (phase_q == 2'd0) ? SRC_P :
						(phase_q == 2'd1) ? SRC_B : SRC_DONE;
					if (phase_q == 2'd0)
						phase_d_w = (!stat.a_in) ? 2'd1 : 2'd3;
					else if (phase_q == 2'd1)
						phase_d_w = 2'd3;
					else
						phase_d_w = 2'd3;
					cmd.emit_last = (phase_q == 2'd2) ||
						(phase_d_w == 2'd3 && !stat.closes);
					if (out_free) begin
						cmd.emit = 1'b1;
						if (phase_q == 2'd2) begin
							cmd.commit = 1'b1;
							state_d = ST_IDLE;
						end else begin
							phase_d = phase_d_w;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/pclip_dp.sv -----
// ----------------------------------------------------------------------------
// pclip_dp: clipper datapath
// Distance MAC, edge registers, restoring divider, interpolation and output.
// ----------------------------------------------------------------------------
module pclip_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_data,
	input  pclip_pkg::vert_in_t in_data,
	input  pclip_pkg::dp_cmd_t  cmd,
	output pclip_pkg::dp_stat_t stat,
	output logic                out_valid,
	input  logic                out_stall,
	output pclip_pkg::vert_out_t out_data
);
	import pclip_pkg::*;

	logic signed [15:0] nx_q, ny_q, nz_q;
	logic signed [31:0] off_q;
	vert_in_t           cur_q;
	logic [1:0]         dstep_q;
	logic signed [DistW-1:0] dcur_q, dfirst_q, dprev_q;
	logic signed [31:0] first_q [3];
	logic signed [31:0] prev_q [3];
	logic               inpoly_q;
	logic [7:0]         cnt_q;
	logic signed [31:0] a_q [3];
	logic signed [31:0] b_q [3];
	logic signed [DistW-1:0] da_q, db_q;
	logic [DistW-1:0]   rem_q, den_q;
	logic [16:0]        t_q;
	logic [4:0]         dcnt_q;
	logic [1:0]         lcnt_q;
	logic signed [31:0] p_q [3];
	logic               ovld_q;
	vert_out_t          odat_q;
	vert_out_t          odat_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0; ny_q <= '0; nz_q <= 16'sd16384; off_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegNormalX: nx_q  <= cfg_data[15:0];
				RegNormalY: ny_q  <= cfg_data[15:0];
				RegNormalZ: nz_q  <= cfg_data[15:0];
				RegOffset:  off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// distance term for the current step, one product per cycle
	logic signed [47:0] prod;
	logic signed [15:0] mul_a;
	logic signed [31:0] mul_b;
	always_comb begin
		case (dstep_q)
			2'd0: begin mul_a = nx_q; mul_b = cur_q.vert_x; end
			2'd1: begin mul_a = ny_q; mul_b = cur_q.vert_y; end
			2'd2: begin mul_a = nz_q; mul_b = cur_q.vert_z; end
			default: begin mul_a = -16'sd16384; mul_b = off_q; end
		endcase
		prod = mul_a * mul_b;
	end

	// intersection step for one coordinate
	logic signed [32:0] delta;
	logic [32:0]        mag;
	logic [49:0]        mprod;
	logic signed [33:0] stepv;
	logic signed [33:0] psum;
	logic [DistW-1:0]   rem_sh;
	always_comb begin
		delta  = 33'(b_q[lcnt_q]) - 33'(a_q[lcnt_q]);
		mag    = delta[32] ? 33'(-delta) : 33'(delta);
		mprod  = mag * t_q;
		stepv  = 34'({1'b0, mprod[48:16]});
		psum   = 34'(a_q[lcnt_q]) + (delta[32] ? -stepv : stepv);
		rem_sh = {rem_q[DistW-2:0], 1'b0};
	end

	logic signed [DistW-1:0] dab;
	assign dab = da_q - db_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) cur_q <= in_data;
		if (cmd.dist_clr) begin
			dcur_q <= '0; dstep_q <= 2'd0;
		end else if (cmd.dist_step) begin
			dcur_q <= dcur_q + DistW'(prod);
			dstep_q <= dstep_q + 2'd1;
		end
		// edge operands
		if (cmd.set_edge) begin
			if (cmd.edge_close) begin
				a_q[0] <= cur_q.vert_x; a_q[1] <= cur_q.vert_y; a_q[2] <= cur_q.vert_z;
				da_q <= dcur_q;
				db_q <= inpoly_q ? dfirst_q : dcur_q;
				if (inpoly_q) begin
					b_q <= first_q;
				end else begin
					b_q[0] <= cur_q.vert_x; b_q[1] <= cur_q.vert_y;
					b_q[2] <= cur_q.vert_z;
				end
			end else begin
				a_q <= prev_q; da_q <= dprev_q;
				b_q[0] <= cur_q.vert_x; b_q[1] <= cur_q.vert_y; b_q[2] <= cur_q.vert_z;
				db_q <= dcur_q;
			end
		end
		// restoring divider, one quotient bit a cycle
		if (cmd.div_start) begin
			dcnt_q <= 5'd0;
			t_q <= '0;
		end else if (cmd.div_step && dcnt_q == 5'd0) begin
			rem_q <= da_q[DistW-1] ? DistW'(-da_q) : DistW'(da_q);
			den_q <= dab[DistW-1] ? DistW'(-dab) : DistW'(dab);
			dcnt_q <= 5'd1;
		end else if (cmd.div_step && dcnt_q == 5'd1 && rem_q >= den_q) begin
			t_q <= 17'h10000;
			dcnt_q <= 5'd17;
		end else if (cmd.div_step) begin
			if (rem_sh >= den_q) begin
				rem_q <= rem_sh - den_q; t_q <= {t_q[15:0], 1'b1};
			end else begin
				rem_q <= rem_sh; t_q <= {t_q[15:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 5'd1;
		end
		if (cmd.div_start) lcnt_q <= 2'd0;
		else if (cmd.lerp_step) begin
			p_q[lcnt_q] <= psum[31:0];
			lcnt_q <= lcnt_q + 2'd1;
		end
	end

	// polygon state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inpoly_q <= 1'b0; cnt_q <= '0;
			dfirst_q <= '0; dprev_q <= '0;
			first_q <= '{default: '0}; prev_q <= '{default: '0};
		end else begin
			if (cmd.emit && cmd.emit_src != SRC_DONE && cnt_q < CountCap)
				cnt_q <= cnt_q + 8'd1;
			if (cmd.commit) begin
				prev_q[0] <= cur_q.vert_x; prev_q[1] <= cur_q.vert_y;
				prev_q[2] <= cur_q.vert_z;
				dprev_q <= dcur_q;
				if (!inpoly_q) begin
					first_q[0] <= cur_q.vert_x; first_q[1] <= cur_q.vert_y;
					first_q[2] <= cur_q.vert_z;
					dfirst_q <= dcur_q;
				end
				inpoly_q <= !cur_q.closes_polygon;
				if (!inpoly_q || cur_q.closes_polygon) cnt_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovld_q <= 1'b0;
		else if (cmd.emit) ovld_q <= 1'b1;
		else if (!out_stall) ovld_q <= 1'b0;
	end

	// assemble the next output item
	always_comb begin
		odat_d = '0;
		odat_d.run_end = cmd.emit_last;
		case (cmd.emit_src)
			SRC_P: begin
				odat_d.out_x = p_q[0]; odat_d.out_y = p_q[1];
				odat_d.out_z = p_q[2]; odat_d.vertex_valid = 1'b1;
			end
			SRC_B: begin
				odat_d.out_x = b_q[0]; odat_d.out_y = b_q[1];
				odat_d.out_z = b_q[2]; odat_d.vertex_valid = 1'b1;
			end
			default: begin
				odat_d.polygon_done = 1'b1;
				odat_d.vertex_count = cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) odat_q <= odat_d;
	end

	assign out_valid = ovld_q;
	assign out_data  = odat_q;

	assign stat.a_in      = (da_q <= 0);
	assign stat.b_in      = (db_q <= 0);
	assign stat.div_done  = (dcnt_q == 5'd17);
	assign stat.lerp_done = (lcnt_q == 2'd2);
	assign stat.first_vtx = !inpoly_q;
	assign stat.closes    = cur_q.closes_polygon;

endmodule

// ----- tb/polygon_clip_against_plane_tb.sv -----
// ----------------------------------------------------------------------------
// polygon_clip_against_plane_tb: self-checking bench for the plane clipper
// Streams polygons under several plane settings and idle patterns, predicts
// each clipped vertex and done item, and compares every output transfer.
// ----------------------------------------------------------------------------
module polygon_clip_against_plane_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pclip_pkg::*;

	localparam int WatchLimit = 20000;

	// ------------------------------------------------------------------
	// Clip predictor and expected-vertex store
	// ------------------------------------------------------------------
	class clip_scoreboard;
		longint nx, ny, nz, offs;
		longint first_v[3], prev_v[3];
		longint first_d, prev_d;
		int     count;
		bit     open_poly;
		vert_out_t pending[$];
		int     errors, checked, polygons;

		function void reset_state();
			nx = 0; ny = 0; nz = 16384; offs = 0;
			first_v = '{0, 0, 0}; prev_v = '{0, 0, 0};
			first_d = 0; prev_d = 0; count = 0; open_poly = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				RegNormalX: nx = longint'($signed(val[15:0]));
				RegNormalY: ny = longint'($signed(val[15:0]));
				RegNormalZ: nz = longint'($signed(val[15:0]));
				RegOffset:  offs = longint'($signed(val));
				default: ;
			endcase
		endfunction

		function void push_vertex(longint v[3]);
			vert_out_t r;
			r = '0;
			r.out_x = v[0][31:0]; r.out_y = v[1][31:0]; r.out_z = v[2][31:0];
			r.vertex_valid = 1'b1;
			pending.push_back(r);
			if (count < int'(CountCap))
				count++;
		endfunction

		function void crossing(longint a[3], longint da, longint b[3], longint db);
			longint p[3], diff, delta, stp;
			longint unsigned num, den, rem, t, mag;
			num = da < 0 ? -da : da;
			diff = da - db;
			den = diff < 0 ? -diff : diff;
			t = 0;
			if (num >= den)
				t = 65536;
			else begin
				rem = num;
				for (int i = 0; i < 16; i++) begin
					rem = rem << 1;
					t = t << 1;
					if (rem >= den) begin
						rem -= den;
						t |= 1;
					end
				end
			end
			for (int i = 0; i < 3; i++) begin
				delta = b[i] - a[i];
				mag = delta < 0 ? -delta : delta;
				stp = longint'((mag * t) >> 16);
				p[i] = a[i] + (delta < 0 ? -stp : stp);
			end
			push_vertex(p);
		endfunction

		function void clip_edge(longint a[3], longint da, longint b[3], longint db);
			if (da <= 0 && db <= 0)
				push_vertex(b);
			else if (da <= 0)
				crossing(a, da, b, db);
			else if (db <= 0) begin
				crossing(a, da, b, db);
				push_vertex(b);
			end
		endfunction

		// Note an accepted input vertex and queue the items it produces
		function void note_vertex(vert_in_t item);
			longint v[3], d;
			vert_out_t r;
			int base;
			base = pending.size();
			v[0] = item.vert_x; v[1] = item.vert_y; v[2] = item.vert_z;
			d = nx * v[0] + ny * v[1] + nz * v[2] - offs * 16384;
			if (!open_poly) begin
				first_v = v; first_d = d; count = 0; open_poly = 1;
			end else
				clip_edge(prev_v, prev_d, v, d);
			prev_v = v; prev_d = d;
			if (item.closes_polygon) begin
				clip_edge(v, d, first_v, first_d);
				r = '0;
				r.polygon_done = 1'b1;
				r.vertex_count = 8'(count);
				pending.push_back(r);
				open_poly = 0; count = 0; polygons++;
			end
			if (pending.size() > base)
				pending[pending.size() - 1].run_end = 1'b1;
		endfunction

		task report(string field, longint got, longint want);
			$display("mismatch %0s: got %0h expected %0h at %0t", field, got, want, $realtime);
			errors++;
		endtask

		// Check one output transfer against the oldest expected item
		task check(vert_out_t got);
			vert_out_t want;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected item", 0, 0);
				return;
			end
			want = pending.pop_front();
			if (got.out_x != want.out_x) report("out_x", got.out_x, want.out_x);
			if (got.out_y != want.out_y) report("out_y", got.out_y, want.out_y);
			if (got.out_z != want.out_z) report("out_z", got.out_z, want.out_z);
			if (got.vertex_valid != want.vertex_valid)
				report("vertex_valid", got.vertex_valid, want.vertex_valid);
			if (got.polygon_done != want.polygon_done)
				report("polygon_done", got.polygon_done, want.polygon_done);
			if (got.vertex_count != want.vertex_count)
				report("vertex_count", got.vertex_count, want.vertex_count);
			if (got.run_end != want.run_end) report("run_end", got.run_end, want.run_end);
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	vert_in_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	vert_out_t out_data;

	clip_scoreboard sb = new();
	int send_idle = 0, recv_idle = 0, quiet = 0, sent = 0;

	polygon_clip_against_plane uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check output transfers and randomize receiver stall
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check(out_data);
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WatchLimit) begin
			$display("timeout: no transfer for %0d cycles", quiet);
			$display("FAIL");
			$finish;
		end
	end

	task write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task set_plane(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] o);
		write_reg(RegNormalX, x);
		write_reg(RegNormalY, y);
		write_reg(RegNormalZ, z);
		write_reg(RegOffset, o);
		cfg_we <= 1'b0;
	endtask

	// Send one vertex, idling first at the sender's rate
	task send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
		vert_in_t item;
		item.vert_x = x; item.vert_y = y; item.vert_z = z; item.closes_polygon = last;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		sb.note_vertex(item);
		sent++;
	endtask

	// Hold until every expected item has arrived, then let the block settle
	task drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function logic [31:0] rand_coord();
		if ($urandom_range(7) == 0)
			return $urandom();
		return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
	endfunction

	function logic [31:0] rand_normal();
		case ($urandom_range(5))
			0: return {16'($urandom_range(65535)), 16'h8000};
			1: return {16'($urandom_range(65535)), 16'h7fff};
			default: return $urandom();
		endcase
	endfunction

	task random_polygon(int n);
		for (int i = 0; i < n; i++)
			send_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
	endtask

	initial begin
		sb.reset_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default plane z <= 0 is inside
		send_vertex(0, 0, 32'hfffe0000, 0);
		send_vertex(32'h00010000, 0, 32'h00020000, 0);
		send_vertex(0, 32'h00010000, 32'hffff0000, 1);
		send_vertex(5, 6, 32'hffffffff, 1);          // one vertex, inside
		send_vertex(5, 6, 32'h00000001, 1);          // one vertex, outside
		send_vertex(0, 0, 32'h00010000, 0);          // all outside: empty steps
		send_vertex(1, 0, 32'h00020000, 0);
		send_vertex(0, 1, 32'h00030000, 1);
		send_vertex(32'h7fffffff, 32'h80000000, 32'h80000000, 0);
		send_vertex(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
		send_vertex(32'h7fffffff, 32'h7fffffff, 0, 1);
		drain();

		// Directed: extreme normals and offsets
		set_plane(32'hffff8000, 32'h00007fff, 32'hffff8000, 32'h80000000);
		send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 0);
		send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
		send_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff, 1);
		drain();
		set_plane(32'h12347fff, 32'hffff8000, 32'h00007fff, 32'h7fffffff);
		send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
		send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 0);
		send_vertex(0, 0, 0, 0);
		send_vertex(32'h00400000, 32'hffc00000, 32'h00400000, 1);
		drain();

		// Random phases: sender idles lightly, then receiver, then neither
		for (int ph = 0; ph < 6; ph++) begin
			send_idle = (ph < 2) ? 11 : (ph < 4) ? 61 : 0;
			recv_idle = (ph < 2) ? 61 : (ph < 4) ? 11 : 0;
			set_plane(rand_normal(), rand_normal(), rand_normal(),
				($urandom_range(3) == 0) ? $urandom()
					: 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18));
			for (int n = 0; n < 8; ) begin
				int len;
				len = $urandom_range(1, 7);
				random_polygon(len);
				n += len;
			end
			drain();
		end

		// Long polygon, fully inside, drives the count into saturation
		set_plane(0, 0, 32'h00004000, 32'h00640000);
		for (int i = 0; i < 130; i++)
			send_vertex(rand_coord() & 32'h0003ffff, rand_coord() & 32'h0003ffff,
				32'($urandom_range(0, 1 << 20)), i == 129);
		drain();

		$display("covered %0d vertices in %0d polygons, %0d output items checked",
			sent, sb.polygons, sb.checked);
		$display("plane settings: reset, extremes, six random, one saturating run");
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/core/pclip_pkg.sv
rtl/core/pclip_ctrl.sv
rtl/core/pclip_dp.sv
rtl/core/polygon_clip_against_plane.sv
tb/polygon_clip_against_plane_tb.sv
